FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define FISQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define FISQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/fisq_pkg.sv
`timescale 1ns / 1ps

package fisq_pkg;

	localparam int unsigned SEED_STAGES   = 3;
	localparam int unsigned NEWTON_STAGES = 5;

	localparam logic [31:0] SAT_VALUE = 32'h7fffffff;
	localparam logic [15:0] INV_SQRT2 = 16'hb504;
	localparam logic [47:0] THREE_Q16 = 48'h30000;

	typedef logic signed [31:0] fix_t;

	function automatic logic [15:0] seed_lookup(input logic [2:0] idx);
		logic [15:0] s;
		case (idx)
			3'd0: s = 16'hb504;
			3'd1: s = 16'haaaa;
			3'd2: s = 16'ha1e8;
			3'd3: s = 16'h9a5f;
			3'd4: s = 16'h93cd;
			3'd5: s = 16'h8e00;
			3'd6: s = 16'h88d6;
			default: s = 16'h8432;
		endcase
		return s;
	endfunction

endpackage

FILE: hw/rtl/fisq_seed.sv
`timescale 1ns / 1ps

module fisq_seed import fisq_pkg::*; (
	input  logic                   clk,
	input  logic [SEED_STAGES-1:0] en,
	input  logic [30:0]            operand,
	output fix_t                   x_out,
	output logic [30:0]            a_out,
	output logic                   flag_out
);

	// stage 1: leading one position and range check
	logic [4:0]  msb_c;
	logic [30:0] op_s1;
	logic [4:0]  msb_s1;
	logic        sat_s1;

	always_comb begin
		msb_c = 5'd0;
		for (int i = 0; i < 31; i++) begin
			if (operand[i]) begin
				msb_c = 5'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			op_s1  <= operand;
			msb_s1 <= msb_c;
			sat_s1 <= (operand[30:2] == 29'd0);
		end
	end

	// stage 2: table index, seed and exponent shift
	logic [31:0] wide_c;
	logic [4:0]  idx_sh_c;
	logic [2:0]  idx_c;
	logic [23:0] seed_x_c;
	logic [2:0]  rsh_c;
	logic [3:0]  lsh_c;
	logic [4:0]  rdiff_c;
	logic [4:0]  ldiff_c;
	logic [23:0] xsh_c;
	logic [23:0] xsh_s2;
	logic        odd_s2;
	logic [30:0] op_s2;
	logic        sat_s2;

	always_comb begin
		wide_c   = {op_s1, 1'b0};
		idx_sh_c = msb_s1 - 5'd2;
		idx_c    = 3'(wide_c >> idx_sh_c);
		seed_x_c = {7'd0, seed_lookup(idx_c), 1'b0};
		rdiff_c  = msb_s1 - 5'd15;
		ldiff_c  = 5'd16 - msb_s1;
		rsh_c    = 3'(rdiff_c >> 1);
		lsh_c    = 4'(ldiff_c >> 1);
		if (msb_s1 >= 5'd15) begin
			xsh_c = seed_x_c >> rsh_c;
		end else begin
			xsh_c = seed_x_c << lsh_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			xsh_s2 <= xsh_c;
			odd_s2 <= ~msb_s1[0];
			op_s2  <= op_s1;
			sat_s2 <= sat_s1;
		end
	end

	// stage 3: odd exponent scale by 1/sqrt(2)
	logic [39:0] scl_c;
	logic [23:0] x_s3;
	logic [30:0] op_s3;
	logic        sat_s3;

	assign scl_c = xsh_s2 * INV_SQRT2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			x_s3   <= odd_s2 ? scl_c[39:16] : xsh_s2;
			op_s3  <= op_s2;
			sat_s3 <= sat_s2;
		end
	end

	assign x_out    = fix_t'({8'd0, x_s3});
	assign a_out    = op_s3;
	assign flag_out = sat_s3;

endmodule

FILE: hw/rtl/fisq_newton.sv
`timescale 1ns / 1ps

module fisq_newton import fisq_pkg::*; (
	input  logic                     clk,
	input  logic [NEWTON_STAGES-1:0] en,
	input  fix_t                     x_in,
	input  logic [30:0]              a_in,
	input  logic                     flag_in,
	output fix_t                     x_out,
	output logic [30:0]              a_out,
	output logic                     flag_out
);

	// stage 1: a * x
	logic signed [31:0] a_sx_c;
	logic signed [63:0] p1_c;
	logic signed [63:0] p1_s1;
	fix_t               x_s1;
	logic [30:0]        a_s1;
	logic               flag_s1;

	assign a_sx_c = {1'b0, a_in};
	assign p1_c   = a_sx_c * x_in;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			p1_s1   <= p1_c;
			x_s1    <= x_in;
			a_s1    <= a_in;
			flag_s1 <= flag_in;
		end
	end

	// stage 2: partial products of (a*x >> 16) * x
	logic [47:0]        ax_c;
	logic signed [32:0] ax_lo_c;
	logic [15:0]        ax_hi_c;
	logic [31:0]        x_u_c;
	logic signed [63:0] ml_c;
	logic [31:0]        mh_c;
	logic signed [63:0] ml_s2;
	logic [31:0]        mh_s2;
	fix_t               x_s2;
	logic [30:0]        a_s2;
	logic               flag_s2;

	assign ax_c    = p1_s1[63:16];
	assign ax_lo_c = {1'b0, ax_c[31:0]};
	assign ax_hi_c = ax_c[47:32];
	assign x_u_c   = x_s1;
	assign ml_c    = ax_lo_c * x_s1;
	assign mh_c    = ax_hi_c * x_u_c;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			ml_s2   <= ml_c;
			mh_s2   <= mh_c;
			x_s2    <= x_s1;
			a_s2    <= a_s1;
			flag_s2 <= flag_s1;
		end
	end

	// stage 3: three minus a*x*x, low 48 bits, and x halved
	logic [47:0] t_s3;
	fix_t        half_s3;
	logic [30:0] a_s3;
	logic        flag_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			t_s3    <= THREE_Q16 - ml_s2[63:16] - {mh_s2, 16'h0000};
			half_s3 <= x_s2 >>> 1;
			a_s3    <= a_s2;
			flag_s3 <= flag_s2;
		end
	end

	// stage 4: partial products of half * t
	logic signed [32:0] t_lo_c;
	logic [15:0]        t_hi_c;
	logic [15:0]        half_lo_c;
	logic signed [63:0] ql_c;
	logic [15:0]        qh_c;
	logic signed [63:0] ql_s4;
	logic [15:0]        qh_s4;
	logic [30:0]        a_s4;
	logic               flag_s4;

	assign t_lo_c    = {1'b0, t_s3[31:0]};
	assign t_hi_c    = t_s3[47:32];
	assign half_lo_c = half_s3[15:0];
	assign ql_c      = t_lo_c * half_s3;
	assign qh_c      = t_hi_c * half_lo_c;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			ql_s4   <= ql_c;
			qh_s4   <= qh_c;
			a_s4    <= a_s3;
			flag_s4 <= flag_s3;
		end
	end

	// stage 5: recombine, keep bits 47:16
	fix_t        x_s5;
	logic [30:0] a_s5;
	logic        flag_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			x_s5    <= fix_t'(ql_s4[47:16] + {qh_s4, 16'h0000});
			a_s5    <= a_s4;
			flag_s5 <= flag_s4;
		end
	end

	assign x_out    = x_s5;
	assign a_out    = a_s5;
	assign flag_out = flag_s5;

endmodule

FILE: hw/rtl/fixed_inverse_sqrt.sv
// throughput: one request per cycle while the output is not stalled, set by a 13-stage pipeline
// (3 seed stages, then two Newton-Raphson steps of 5 stages each)
// stages hold when the next one is full and stalled, bubbles are filled
// reset clears only the stage valid bits, the datapath is not reset
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fixed_inverse_sqrt import fisq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [30:0]        operand,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] inv_root,
	output logic               saturated
);

	localparam int unsigned STAGES = SEED_STAGES + 2 * NEWTON_STAGES;

	logic [STAGES-1:0] valid_q;
	logic [STAGES-1:0] en;

	assign en[STAGES-1] = !valid_q[STAGES-1] || !out_stall;

	genvar k;
	generate
		for (k = 0; k < STAGES - 1; k++) begin : g_en
			assign en[k] = !valid_q[k] || en[k+1];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int i = 1; i < STAGES; i++) begin
				if (en[i]) begin
					valid_q[i] <= valid_q[i-1];
				end
			end
		end
	end

	assign in_stall = !en[0];

	fix_t        seed_x;
	logic [30:0] seed_a;
	logic        seed_flag;
	fix_t        nr1_x;
	logic [30:0] nr1_a;
	logic        nr1_flag;
	fix_t        nr2_x;
	logic [30:0] nr2_a;
	logic        nr2_flag;

	fisq_seed u_seed (
		.clk      (clk),
		.en       (en[SEED_STAGES-1:0]),
		.operand  (operand),
		.x_out    (seed_x),
		.a_out    (seed_a),
		.flag_out (seed_flag)
	);

	fisq_newton u_nr1 (
		.clk      (clk),
		.en       (en[SEED_STAGES+NEWTON_STAGES-1:SEED_STAGES]),
		.x_in     (seed_x),
		.a_in     (seed_a),
		.flag_in  (seed_flag),
		.x_out    (nr1_x),
		.a_out    (nr1_a),
		.flag_out (nr1_flag)
	);

	fisq_newton u_nr2 (
		.clk      (clk),
		.en       (en[STAGES-1:SEED_STAGES+NEWTON_STAGES]),
		.x_in     (nr1_x),
		.a_in     (nr1_a),
		.flag_in  (nr1_flag),
		.x_out    (nr2_x),
		.a_out    (nr2_a),
		.flag_out (nr2_flag)
	);

	assign out_valid = valid_q[STAGES-1];
	assign inv_root  = nr2_flag ? $signed(SAT_VALUE) : nr2_x;
	assign saturated = nr2_flag;

	`FISQ_ASSERT_NOW(a_free_flow, !out_stall, !in_stall, "stall with free output")
	`FISQ_ASSERT_NOW(a_full_stall, in_stall, (&valid_q) && out_stall, "stall with a bubble")
	`FISQ_ASSERT_NEXT(a_enter, in_valid && !in_stall, valid_q[0], "request lost at entry")
	`FISQ_ASSERT_NOW(a_sat_flag, out_valid, nr2_flag == (nr2_a[30:2] == 29'd0), "range flag mismatch")

endmodule
